[src/epid_pkg.sv]
// shared types and constants for the encoder position pid core
`timescale 1ns / 1ps
`default_nettype none

package epid_pkg;

  localparam int unsigned DivW   = 96;
  localparam int unsigned DerivW = 54;
  localparam int unsigned CntW   = 6;

  localparam logic [19:0] MicroPerSec = 20'd1000000;
  localparam logic [7:0]  MagLimit    = 8'd255;

  localparam logic [CntW-1:0] DivDLast = CntW'(DerivW / 2 - 1);
  localparam logic [CntW-1:0] DivILast = CntW'(DivW / 2 - 1);

  localparam logic OpEdge = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [1:0] {
    CFG_TARGET = 2'd0,
    CFG_KP     = 2'd1,
    CFG_KD     = 2'd2,
    CFG_KI     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULD,
    ST_DIVD,
    ST_MULE,
    ST_INTEG,
    ST_MLO,
    ST_MHI,
    ST_MACC,
    ST_DIVI,
    ST_ADDI,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_D,
    TERM_I
  } term_e;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

[src/epid_div.sv]
// shared restoring divider, two quotient bits per cycle while step is asserted
`timescale 1ns / 1ps
`default_nettype none

module epid_div (
  input  wire                                clk_i,
  input  epid_pkg::div_ctl_t                 ctl_i,
  input  wire  [epid_pkg::DivW-1:0]          dividend_i,
  input  wire  [19:0]                        divisor_i,
  output logic [epid_pkg::DivW-1:0]          quotient_o
);

  logic [epid_pkg::DivW-1:0] dq_q, dq_d;
  logic [19:0]               rem_q, rem_d;
  logic [19:0]               dvs_q;
  logic [20:0]               sh;

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    sh    = '0;
    for (int i = 0; i < 2; i++) begin
      sh   = {rem_d, dq_d[epid_pkg::DivW-1]};
      dq_d = {dq_d[epid_pkg::DivW-2:0], 1'b0};
      if (sh >= {1'b0, dvs_q}) begin
        sh       = sh - {1'b0, dvs_q};
        dq_d[0]  = 1'b1;
      end
      rem_d = sh[19:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (ctl_i.step) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dq_q;

endmodule

`default_nettype wire

[src/encoder_position_pid_motor_drive_core.sv]
// top level: quadrature position count and pid step driving a pwm motor output
`timescale 1ns / 1ps
`default_nettype none

// An encoder edge beat moves the position count and leaves the core ready, with no result. A
// control tick beat keeps the core busy until its result is offered and the core returns to
// idle. One 32x32 multiplier and one divider that retires two quotient bits per cycle are
// shared under a small sequencer, which uses the divider for the derivative and for the scaled
// integral term. The result register lets a finished result wait while new beats are taken.
module encoder_position_pid_motor_drive_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         op_i,
  input  wire         phase_b_i,
  input  wire  [19:0] elapsed_us_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        drive_direction_high_o,
  output logic [7:0]  drive_duty_o,
  output logic [7:0]  drive_magnitude_o
);

  localparam int unsigned W = epid_pkg::DivW;

  epid_pkg::state_e state_q, state_d;
  epid_pkg::term_e  term_q, term_d;
  logic [epid_pkg::CntW-1:0] cnt_q, cnt_d;

  logic [31:0] target_q, kp_q, kd_q, ki_q;
  logic [31:0] pos_q, pos_d;
  logic [31:0] prev_q, prev_d;
  logic [63:0] integ_q, integ_d;

  logic [31:0] e_q, e_d;
  logic [19:0] dt_q, dt_d;
  logic        dneg_q, dneg_d;
  logic [51:0] dmag_q, dmag_d;
  logic [63:0] mag_q, mag_d;
  logic        sgn_q, sgn_d;
  logic [63:0] pp_q, pp_d;
  logic [63:0] hold_q, hold_d;
  logic [W-1:0] acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  logic        dir_q, dir_d;
  logic [7:0]  duty_q, duty_d;
  logic [7:0]  omag_q, omag_d;

  logic [32:0] diff, diff_neg;
  logic [31:0] diff_abs, e_abs, gain;
  logic [63:0] integ_abs;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [64:0] pv, prod65, isum;
  logic [W-1:0] add_a, add_x, add_sum;
  logic         add_n;
  logic         res_neg;
  logic [W-1:0] res_abs;
  logic [7:0]   res_mag;

  epid_pkg::div_ctl_t div_ctl;
  logic [W-1:0] div_dividend, div_quot;
  logic [19:0]  div_divisor;

  epid_div u_div (
    .clk_i      (clk_i),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot)
  );

  // shared datapath pieces
  assign diff      = {e_q[31], e_q} - {prev_q[31], prev_q};
  assign diff_neg  = 33'd0 - diff;
  assign diff_abs  = diff[32] ? diff_neg[31:0] : diff[31:0];
  assign e_abs     = e_q[31] ? (32'd0 - e_q) : e_q;
  assign integ_abs = integ_q[63] ? (64'd0 - integ_q) : integ_q;

  always_comb begin
    case (term_q)
      epid_pkg::TERM_P: gain = kp_q;
      epid_pkg::TERM_D: gain = kd_q;
      default:          gain = ki_q;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // saturating integral update
  assign pv     = {13'd0, pp_q[51:0]};
  assign prod65 = e_q[31] ? (65'd0 - pv) : pv;
  assign isum   = {integ_q[63], integ_q} + prod65;

  assign add_sum = add_a + (add_x ^ {W{add_n}}) + {{(W-1){1'b0}}, add_n};

  assign res_neg = acc_q[W-1];
  assign res_abs = res_neg ? ({W{1'b0}} - acc_q) : acc_q;
  assign res_mag = (|res_abs[W-1:24]) ? epid_pkg::MagLimit : res_abs[23:16];

  always_comb begin
    state_d      = state_q;
    term_d       = term_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    integ_d      = integ_q;
    e_d          = e_q;
    dt_d         = dt_q;
    dneg_d       = dneg_q;
    dmag_d       = dmag_q;
    mag_d        = mag_q;
    sgn_d        = sgn_q;
    pp_d         = pp_q;
    hold_d       = hold_q;
    acc_d        = acc_q;
    dir_d        = dir_q;
    duty_d       = duty_q;
    omag_d       = omag_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    add_a        = acc_q;
    add_x        = '0;
    add_n        = 1'b0;
    div_ctl      = '0;
    div_dividend = '0;
    div_divisor  = dt_q;

    unique case (state_q)
      epid_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == epid_pkg::OpTick) begin
            e_d     = pos_q - target_q;
            dt_d    = (elapsed_us_i == 20'd0) ? 20'd1 : elapsed_us_i;
            acc_d   = '0;
            state_d = epid_pkg::ST_MULD;
          end else begin
            pos_d = phase_b_i ? (pos_q + 32'd1) : (pos_q - 32'd1);
          end
        end
      end
      epid_pkg::ST_MULD: begin
        mul_a        = diff_abs;
        mul_b        = {12'd0, epid_pkg::MicroPerSec};
        div_ctl.load = 1'b1;
        div_dividend = {mul_p[epid_pkg::DerivW-1:0], {(W-epid_pkg::DerivW){1'b0}}};
        div_divisor  = dt_q;
        dneg_d       = diff[32];
        prev_d       = e_q;
        cnt_d        = '0;
        state_d      = epid_pkg::ST_DIVD;
      end
      epid_pkg::ST_DIVD: begin
        div_ctl.step = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == epid_pkg::DivDLast) begin
          state_d = epid_pkg::ST_MULE;
        end
      end
      epid_pkg::ST_MULE: begin
        dmag_d  = div_quot[51:0];
        mul_a   = e_abs;
        mul_b   = {12'd0, dt_q};
        pp_d    = mul_p;
        state_d = epid_pkg::ST_INTEG;
      end
      epid_pkg::ST_INTEG: begin
        if (isum[64] != isum[63]) begin
          integ_d = isum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
          integ_d = isum[63:0];
        end
        mag_d   = {32'd0, e_abs};
        sgn_d   = e_q[31];
        term_d  = epid_pkg::TERM_P;
        state_d = epid_pkg::ST_MLO;
      end
      epid_pkg::ST_MLO: begin
        mul_a   = gain;
        mul_b   = mag_q[31:0];
        pp_d    = mul_p;
        state_d = epid_pkg::ST_MHI;
      end
      epid_pkg::ST_MHI: begin
        if (term_q == epid_pkg::TERM_I) begin
          hold_d = pp_q;
        end else begin
          add_x = {32'd0, pp_q};
          add_n = sgn_q;
          acc_d = add_sum;
        end
        mul_a   = gain;
        mul_b   = mag_q[63:32];
        pp_d    = mul_p;
        state_d = epid_pkg::ST_MACC;
      end
      epid_pkg::ST_MACC: begin
        add_x = {pp_q, 32'd0};
        if (term_q == epid_pkg::TERM_I) begin
          // full 96-bit ki product goes into the divider
          add_a        = {32'd0, hold_q};
          div_ctl.load = 1'b1;
          div_dividend = add_sum;
          div_divisor  = epid_pkg::MicroPerSec;
          cnt_d        = '0;
          state_d      = epid_pkg::ST_DIVI;
        end else begin
          add_n   = sgn_q;
          acc_d   = add_sum;
          state_d = epid_pkg::ST_MLO;
          if (term_q == epid_pkg::TERM_P) begin
            mag_d  = {12'd0, dmag_q};
            sgn_d  = dneg_q;
            term_d = epid_pkg::TERM_D;
          end else begin
            mag_d  = integ_abs;
            sgn_d  = integ_q[63];
            term_d = epid_pkg::TERM_I;
          end
        end
      end
      epid_pkg::ST_DIVI: begin
        div_ctl.step = 1'b1;
        div_divisor  = epid_pkg::MicroPerSec;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == epid_pkg::DivILast) begin
          state_d = epid_pkg::ST_ADDI;
        end
      end
      epid_pkg::ST_ADDI: begin
        add_x   = div_quot;
        add_n   = sgn_q;
        acc_d   = add_sum;
        state_d = epid_pkg::ST_DONE;
      end
      epid_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          dir_d       = !res_neg;
          omag_d      = res_mag;
          duty_d      = res_neg ? res_mag : (epid_pkg::MagLimit - res_mag);
          state_d     = epid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = epid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= epid_pkg::ST_IDLE;
      term_q      <= epid_pkg::TERM_P;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      prev_q      <= '0;
      integ_q     <= '0;
      target_q    <= 32'd0;
      kp_q        <= 32'd6553600;
      kd_q        <= 32'd9830;
      ki_q        <= 32'd0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      if (cfg_we_i) begin
        unique case (epid_pkg::cfg_idx_e'(cfg_idx_i))
          epid_pkg::CFG_TARGET: target_q <= cfg_data_i;
          epid_pkg::CFG_KP:     kp_q     <= cfg_data_i;
          epid_pkg::CFG_KD:     kd_q     <= cfg_data_i;
          epid_pkg::CFG_KI:     ki_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    dt_q   <= dt_d;
    dneg_q <= dneg_d;
    dmag_q <= dmag_d;
    mag_q  <= mag_d;
    sgn_q  <= sgn_d;
    pp_q   <= pp_d;
    hold_q <= hold_d;
    acc_q  <= acc_d;
    dir_q  <= dir_d;
    duty_q <= duty_d;
    omag_q <= omag_d;
  end

  assign out_valid_o            = out_valid_q;
  assign drive_direction_high_o = dir_q;
  assign drive_duty_o           = duty_q;
  assign drive_magnitude_o      = omag_q;

`ifndef SYNTH
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i == epid_pkg::OpTick) |=> state_q == epid_pkg::ST_MULD)
    else $error("tick beat did not start the pid sequence");

  a_edge_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i == epid_pkg::OpEdge)
      |=> (state_q == epid_pkg::ST_IDLE) && (pos_q != $past(pos_q)))
    else $error("edge beat did not move the position count");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == epid_pkg::ST_DONE))
    else $error("result appeared outside the done step");

  a_duty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((drive_direction_high_o &&
                      drive_duty_o == epid_pkg::MagLimit - drive_magnitude_o) ||
                     (!drive_direction_high_o && drive_duty_o == drive_magnitude_o)))
    else $error("duty does not match direction and magnitude");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == epid_pkg::ST_DIVD) |-> (cnt_q <= epid_pkg::DivDLast))
    else $error("derivative divide ran past its length");
`endif

endmodule

`default_nettype wire
